[hdl/atci_pkg.sv]
// ----------------------------------------------------------------------------
// atci_pkg: shared types and constants for the ATA command issuer
// Request and register-write payloads, write slot codes, select bytes,
// opcodes.
// ----------------------------------------------------------------------------
package atci_pkg;

  // Request from the host side
  typedef struct packed {
    logic [47:0] start_sector;
    logic [15:0] sector_count;
    logic        is_read;
    logic        use_dma;
    logic        slave_target;
  } req_t;

  // One register write (or the reject marker)
  typedef struct packed {
    logic       target_block;
    logic [2:0] reg_offset;
    logic [7:0] write_value;
    logic       rejected;
    logic       last_write;
  } wr_t;

  // Write slots, in issue order
  localparam int NUM_SLOTS = 13;
  localparam int SLOT_W    = 4;

  typedef enum logic [SLOT_W-1:0] {
    SLOT_BM_CMD   = 4'd0,
    SLOT_SELECT   = 4'd1,
    SLOT_CNT_HI   = 4'd2,
    SLOT_LBA3     = 4'd3,
    SLOT_LBA4     = 4'd4,
    SLOT_LBA5     = 4'd5,
    SLOT_CNT_LO   = 4'd6,
    SLOT_LBA0     = 4'd7,
    SLOT_LBA1     = 4'd8,
    SLOT_LBA2     = 4'd9,
    SLOT_COMMAND  = 4'd10,
    SLOT_BM_START = 4'd11,
    SLOT_REJECT   = 4'd12
  } slot_t;

  typedef logic [NUM_SLOTS-1:0] slot_mask_t;

  // Plan handed from the decoder to the sequencer
  typedef struct packed {
    slot_mask_t mask;
    logic [7:0] sel;
    logic       wide;
    logic       sel_write;
  } plan_t;

  // Register blocks
  localparam logic BLK_TASKFILE = 1'b0;
  localparam logic BLK_BUSMSTR  = 1'b1;

  // Taskfile offsets
  localparam logic [2:0] OFS_COUNT   = 3'd2;
  localparam logic [2:0] OFS_LBA_LO  = 3'd3;
  localparam logic [2:0] OFS_LBA_MID = 3'd4;
  localparam logic [2:0] OFS_LBA_HI  = 3'd5;
  localparam logic [2:0] OFS_SELECT  = 3'd6;
  localparam logic [2:0] OFS_COMMAND = 3'd7;
  localparam logic [2:0] OFS_BM_CMD  = 3'd0;

  // Config register indexes
  localparam logic CFG_MASTER_LBA48 = 1'b0;
  localparam logic CFG_SLAVE_LBA48  = 1'b1;

  localparam logic [3:0] SEL_MASTER_HI = 4'hE;
  localparam logic [3:0] SEL_SLAVE_HI  = 4'hF;

  localparam logic [7:0] BM_READ  = 8'h08;
  localparam logic [7:0] BM_WRITE = 8'h00;
  localparam logic [7:0] BM_START = 8'h01;

  localparam logic [7:0] OP_READ_PIO      = 8'h20;
  localparam logic [7:0] OP_READ_PIO_EXT  = 8'h24;
  localparam logic [7:0] OP_READ_DMA      = 8'hC8;
  localparam logic [7:0] OP_READ_DMA_EXT  = 8'h25;
  localparam logic [7:0] OP_WRITE_PIO     = 8'h30;
  localparam logic [7:0] OP_WRITE_PIO_EXT = 8'h34;
  localparam logic [7:0] OP_WRITE_DMA     = 8'hCA;
  localparam logic [7:0] OP_WRITE_DMA_EXT = 8'h35;

  function automatic logic [7:0] opcode(input logic rd, input logic dma, input logic wide);
    logic [7:0] op;
    if (dma) begin
      if (rd) op = wide ? OP_READ_DMA_EXT : OP_READ_DMA;
      else    op = wide ? OP_WRITE_DMA_EXT : OP_WRITE_DMA;
    end else begin
      if (rd) op = wide ? OP_READ_PIO_EXT : OP_READ_PIO;
      else    op = wide ? OP_WRITE_PIO_EXT : OP_WRITE_PIO;
    end
    return op;
  endfunction

endpackage

[hdl/atci_plan.sv]
// ----------------------------------------------------------------------------
// atci_plan: request decoder
// Picks address mode, select byte and the set of writes a request needs.
// ----------------------------------------------------------------------------
module atci_plan (
  input  atci_pkg::req_t  req,
  input  logic            master_lba48,
  input  logic            slave_lba48,
  input  logic [7:0]      current_select,
  output atci_pkg::plan_t plan
);

  logic       wide;
  logic       reject;
  logic [7:0] sel;

  always_comb begin
    wide   = req.slave_target ? slave_lba48 : master_lba48;
    // 28-bit drive cannot reach sectors past bit 27
    reject = !wide && (|req.start_sector[47:28]);
    sel    = {req.slave_target ? atci_pkg::SEL_SLAVE_HI : atci_pkg::SEL_MASTER_HI,
              wide ? 4'h0 : req.start_sector[27:24]};

    plan.mask = '0;
    if (reject) begin
      plan.mask[atci_pkg::SLOT_REJECT] = 1'b1;
    end else begin
      plan.mask[atci_pkg::SLOT_BM_CMD]   = req.use_dma;
      plan.mask[atci_pkg::SLOT_SELECT]   = (sel != current_select);
      plan.mask[atci_pkg::SLOT_CNT_HI]   = wide;
      plan.mask[atci_pkg::SLOT_LBA3]     = wide;
      plan.mask[atci_pkg::SLOT_LBA4]     = wide;
      plan.mask[atci_pkg::SLOT_LBA5]     = wide;
      plan.mask[atci_pkg::SLOT_CNT_LO]   = 1'b1;
      plan.mask[atci_pkg::SLOT_LBA0]     = 1'b1;
      plan.mask[atci_pkg::SLOT_LBA1]     = 1'b1;
      plan.mask[atci_pkg::SLOT_LBA2]     = 1'b1;
      plan.mask[atci_pkg::SLOT_COMMAND]  = 1'b1;
      plan.mask[atci_pkg::SLOT_BM_START] = req.use_dma;
    end
    plan.sel       = sel;
    plan.wide      = wide;
    plan.sel_write = !reject && (sel != current_select);
  end

endmodule

[hdl/atci_seq.sv]
// ----------------------------------------------------------------------------
// atci_seq: write sequencer
// Holds one planned request and issues its writes, lowest slot first, one
// per cycle into the output register while wr is not stalled.
// ----------------------------------------------------------------------------
module atci_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  atci_pkg::req_t  req,
  input  atci_pkg::plan_t plan,
  output logic            ready,
  output logic            wr_valid,
  input  logic            wr_stall,
  output atci_pkg::wr_t   wr
);

  atci_pkg::slot_mask_t pending;
  atci_pkg::slot_mask_t pending_clr;
  atci_pkg::slot_t      pick;
  atci_pkg::wr_t        result;
  logic                 adv;
  logic                 last;

  // held request
  logic [47:0] sector;
  logic [15:0] count;
  logic        rd;
  logic        dma;
  logic        wide;
  logic [7:0]  sel;
  logic [7:0]  bm;

  // lowest pending slot
  always_comb begin
    pick = atci_pkg::SLOT_BM_CMD;
    for (int i = atci_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (pending[i]) pick = atci_pkg::slot_t'(atci_pkg::SLOT_W'(i));
    end
    pending_clr = pending;
    pending_clr[pick] = 1'b0;
    last  = (pending_clr == '0);
    adv   = !wr_valid || !wr_stall;
    ready = (pending == '0) || (adv && last);
  end

  always_comb begin
    bm = rd ? atci_pkg::BM_READ : atci_pkg::BM_WRITE;
    result = '0;
    result.target_block = atci_pkg::BLK_TASKFILE;
    result.last_write   = last;
    unique case (pick)
      atci_pkg::SLOT_BM_CMD: begin
        result.target_block = atci_pkg::BLK_BUSMSTR;
        result.reg_offset   = atci_pkg::OFS_BM_CMD;
        result.write_value  = bm;
      end
      atci_pkg::SLOT_SELECT: begin
        result.reg_offset  = atci_pkg::OFS_SELECT;
        result.write_value = sel;
      end
      atci_pkg::SLOT_CNT_HI: begin
        result.reg_offset  = atci_pkg::OFS_COUNT;
        result.write_value = count[15:8];
      end
      atci_pkg::SLOT_LBA3: begin
        result.reg_offset  = atci_pkg::OFS_LBA_LO;
        result.write_value = sector[31:24];
      end
      atci_pkg::SLOT_LBA4: begin
        result.reg_offset  = atci_pkg::OFS_LBA_MID;
        result.write_value = sector[39:32];
      end
      atci_pkg::SLOT_LBA5: begin
        result.reg_offset  = atci_pkg::OFS_LBA_HI;
        result.write_value = sector[47:40];
      end
      atci_pkg::SLOT_CNT_LO: begin
        result.reg_offset  = atci_pkg::OFS_COUNT;
        result.write_value = count[7:0];
      end
      atci_pkg::SLOT_LBA0: begin
        result.reg_offset  = atci_pkg::OFS_LBA_LO;
        result.write_value = sector[7:0];
      end
      atci_pkg::SLOT_LBA1: begin
        result.reg_offset  = atci_pkg::OFS_LBA_MID;
        result.write_value = sector[15:8];
      end
      atci_pkg::SLOT_LBA2: begin
        result.reg_offset  = atci_pkg::OFS_LBA_HI;
        result.write_value = sector[23:16];
      end
      atci_pkg::SLOT_COMMAND: begin
        result.reg_offset  = atci_pkg::OFS_COMMAND;
        result.write_value = atci_pkg::opcode(rd, dma, wide);
      end
      atci_pkg::SLOT_BM_START: begin
        result.target_block = atci_pkg::BLK_BUSMSTR;
        result.reg_offset   = atci_pkg::OFS_BM_CMD;
        result.write_value  = bm | atci_pkg::BM_START;
      end
      atci_pkg::SLOT_REJECT: begin
        result.rejected = 1'b1;
      end
      default: begin
        result = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= '0;
      wr_valid <= 1'b0;
    end else begin
      if (adv) wr_valid <= |pending;
      if (load)     pending <= plan.mask;
      else if (adv) pending <= pending_clr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && (|pending)) wr <= result;
    if (load) begin
      sector <= req.start_sector;
      count  <= req.sector_count;
      rd     <= req.is_read;
      dma    <= req.use_dma;
      wide   <= plan.wide;
      sel    <= plan.sel;
    end
  end

endmodule

[hdl/ata_taskfile_command_issuer_core.sv]
// ----------------------------------------------------------------------------
// ata_taskfile_command_issuer_core: ATA command issue sequencer
// Turns one transfer request into the ordered register writes that issue
// an LBA28 or LBA48 ATA command, with optional bus-master DMA writes.
// ----------------------------------------------------------------------------
// A request is taken on the req channel and comes out as 1 to 12 register
// writes on the wr channel, one write per cycle when wr is not stalled; the
// final write of a request has last_write set. A request for a sector past
// the 28-bit range on a drive without LBA48 gives a single write with
// rejected and last_write set and nothing else. The next request is taken
// in the same cycle the previous request's last write moves into the output
// register, so requests run back to back and the wr channel stays busy;
// throughput is set by the write count of each request (the one-write-per-
// cycle sequencer). The drive-select byte is remembered across requests and
// only rewritten when it changes. The lba48 capability bits are to be
// written through the cfg port only while no request is in flight; the
// block itself does not enforce this.
module ata_taskfile_command_issuer_core (
  input  logic           clk,
  input  logic           rst,
  // configuration
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic           cfg_data,
  // request channel
  input  logic           req_valid,
  output logic           req_stall,
  input  atci_pkg::req_t req,
  // register write channel
  output logic           wr_valid,
  input  logic           wr_stall,
  output atci_pkg::wr_t  wr
);

  logic            master_lba48;
  logic            slave_lba48;
  logic [7:0]      current_select;   // last select byte planned for the drive
  atci_pkg::plan_t plan;
  logic            seq_ready;
  logic            accept;

  assign req_stall = !seq_ready;
  assign accept    = req_valid && seq_ready;

  // capability bits
  always_ff @(posedge clk) begin
    if (rst) begin
      master_lba48 <= 1'b0;
      slave_lba48  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        atci_pkg::CFG_MASTER_LBA48: master_lba48 <= cfg_data;
        atci_pkg::CFG_SLAVE_LBA48:  slave_lba48  <= cfg_data;
        default: ;
      endcase
    end
  end

  // select byte tracking: updated as soon as the request is planned, so the
  // next request compares against it even while these writes still drain
  always_ff @(posedge clk) begin
    if (rst) begin
      current_select <= 8'h00;
    end else if (accept && plan.sel_write) begin
      current_select <= plan.sel;
    end
  end

  atci_plan u_plan (
    .req            (req),
    .master_lba48   (master_lba48),
    .slave_lba48    (slave_lba48),
    .current_select (current_select),
    .plan           (plan)
  );

  atci_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .req      (req),
    .plan     (plan),
    .ready    (seq_ready),
    .wr_valid (wr_valid),
    .wr_stall (wr_stall),
    .wr       (wr)
  );

endmodule

[hdl/atci_checker.sv]
// ----------------------------------------------------------------------------
// atci_checker: port-level checks for the ATA command issuer
// Watches the write channel of the top level.
// ----------------------------------------------------------------------------
module atci_checker (
  input logic          clk,
  input logic          rst,
  input logic          wr_valid,
  input logic          wr_stall,
  input atci_pkg::wr_t wr
);

  // stalled write holds
  a_wr_hold: assert property (@(posedge clk) disable iff (rst)
    wr_valid && wr_stall |=> wr_valid && $stable(wr))
    else $error("write changed while stalled");

  // reject marker is the last write and blank
  a_reject: assert property (@(posedge clk) disable iff (rst)
    wr_valid && wr.rejected |->
      wr.last_write && wr.target_block == 1'b0 && wr.reg_offset == 3'd0 &&
      wr.write_value == 8'h00)
    else $error("malformed reject");

  // bus-master writes go to the command register only
  a_bm_ofs: assert property (@(posedge clk) disable iff (rst)
    wr_valid && wr.target_block |->
      wr.reg_offset == atci_pkg::OFS_BM_CMD && !wr.rejected &&
      (wr.write_value == atci_pkg::BM_READ || wr.write_value == atci_pkg::BM_WRITE ||
       wr.write_value == (atci_pkg::BM_READ | atci_pkg::BM_START) ||
       wr.write_value == (atci_pkg::BM_WRITE | atci_pkg::BM_START)))
    else $error("bad bus-master write");

  // a request always closes on the command or the DMA start write
  a_last: assert property (@(posedge clk) disable iff (rst)
    wr_valid && wr.last_write && !wr.rejected |->
      wr.reg_offset == atci_pkg::OFS_COMMAND || wr.target_block)
    else $error("request ended on wrong write");

  // nothing out right after reset
  a_rst: assert property (@(posedge clk) rst |=> !wr_valid)
    else $error("write valid after reset");

endmodule

bind ata_taskfile_command_issuer_core atci_checker u_atci_checker (
  .clk      (clk),
  .rst      (rst),
  .wr_valid (wr_valid),
  .wr_stall (wr_stall),
  .wr       (wr)
);

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for ata_taskfile_command_issuer_core
// Sends transfer requests through a directed table and then random traffic
// under each lba48 setting and several idling mixes. Every register write
// that comes out is checked field by field against a local model of the
// command issue sequence, including the drive-select shadow.
// ----------------------------------------------------------------------------
module tb;
  import atci_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 400;
  localparam int CHUNK        = 50;
  localparam int MAX_PRINTS   = 40;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // One directed row: lba48 setting, request, and whether the result is
  // the fixed out-of-range reject
  typedef struct packed {
    logic m48;
    logic s48;
    req_t rq;
    logic fixed_exp;
  } dir_row_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cfg_we    = 1'b0;
  logic cfg_index = 1'b0;
  logic cfg_data  = 1'b0;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic wr_valid;
  logic wr_stall  = 1'b0;
  wr_t  wr;

  wr_t        due_writes[$];
  dir_row_t   dir_tab[$];
  logic [7:0] sel_shadow = '0;
  logic       lba48_m    = 1'b0;
  logic       lba48_s    = 1'b0;
  logic       fixed_next = 1'b0;
  int         snd_pct    = 0;
  int         rcv_pct    = 0;
  int         mismatches = 0;
  int         cycles     = 0;
  wr_t        got_w;
  wr_t        want_w;

  ata_taskfile_command_issuer_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .wr_valid  (wr_valid),
    .wr_stall  (wr_stall),
    .wr        (wr)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic wr_t reg_write(input logic blk, input logic [2:0] ofs,
                                    input logic [7:0] val);
    wr_t w;
    w = '0;
    w.target_block = blk;
    w.reg_offset   = ofs;
    w.write_value  = val;
    return w;
  endfunction

  function automatic wr_t reject_write();
    wr_t w;
    w = '0;
    w.rejected   = 1'b1;
    w.last_write = 1'b1;
    return w;
  endfunction

  // Expected write sequence for one request; tracks the select shadow
  function automatic void plan_taskfile_writes(input req_t r);
    logic       wide;
    logic [7:0] bm;
    logic [7:0] sel;
    logic [7:0] op;
    wr_t        seq[12];
    int         n;
    n = 0;
    wide = r.slave_target ? lba48_s : lba48_m;
    if (!wide && r.start_sector > 48'h0000_0FFF_FFFF) begin
      due_writes.push_back(reject_write());
      return;
    end
    bm = r.is_read ? BM_READ : BM_WRITE;
    if (r.use_dma) begin
      seq[n] = reg_write(BLK_BUSMSTR, OFS_BM_CMD, bm);
      n++;
    end
    sel = {r.slave_target ? SEL_SLAVE_HI : SEL_MASTER_HI,
           wide ? 4'h0 : r.start_sector[27:24]};
    if (sel != sel_shadow) begin
      sel_shadow = sel;
      seq[n] = reg_write(BLK_TASKFILE, OFS_SELECT, sel);
      n++;
    end
    if (wide) begin
      seq[n]   = reg_write(BLK_TASKFILE, OFS_COUNT,   r.sector_count[15:8]);
      seq[n+1] = reg_write(BLK_TASKFILE, OFS_LBA_LO,  r.start_sector[31:24]);
      seq[n+2] = reg_write(BLK_TASKFILE, OFS_LBA_MID, r.start_sector[39:32]);
      seq[n+3] = reg_write(BLK_TASKFILE, OFS_LBA_HI,  r.start_sector[47:40]);
      n += 4;
    end
    seq[n]   = reg_write(BLK_TASKFILE, OFS_COUNT,   r.sector_count[7:0]);
    seq[n+1] = reg_write(BLK_TASKFILE, OFS_LBA_LO,  r.start_sector[7:0]);
    seq[n+2] = reg_write(BLK_TASKFILE, OFS_LBA_MID, r.start_sector[15:8]);
    seq[n+3] = reg_write(BLK_TASKFILE, OFS_LBA_HI,  r.start_sector[23:16]);
    n += 4;
    if (r.use_dma) begin
      if (r.is_read) op = wide ? OP_READ_DMA_EXT : OP_READ_DMA;
      else           op = wide ? OP_WRITE_DMA_EXT : OP_WRITE_DMA;
    end else begin
      if (r.is_read) op = wide ? OP_READ_PIO_EXT : OP_READ_PIO;
      else           op = wide ? OP_WRITE_PIO_EXT : OP_WRITE_PIO;
    end
    seq[n] = reg_write(BLK_TASKFILE, OFS_COMMAND, op);
    n++;
    if (r.use_dma) begin
      seq[n] = reg_write(BLK_BUSMSTR, OFS_BM_CMD, bm | BM_START);
      n++;
    end
    seq[n-1].last_write = 1'b1;
    for (int i = 0; i < n; i++) due_writes.push_back(seq[i]);
  endfunction

  function automatic dir_row_t mk_row(input logic m, input logic s,
                                      input logic [47:0] sector,
                                      input logic [15:0] count, input logic rd,
                                      input logic dma, input logic slv,
                                      input logic fx);
    dir_row_t d;
    d.m48             = m;
    d.s48             = s;
    d.rq.start_sector = sector;
    d.rq.sector_count = count;
    d.rq.is_read      = rd;
    d.rq.use_dma      = dma;
    d.rq.slave_target = slv;
    d.fixed_exp       = fx;
    return d;
  endfunction

  // Random request; leans on the previous sector nibble and drive so that
  // the select write is skipped often, and hits the 28-bit boundary
  function automatic req_t roll_request(input req_t prev);
    req_t        r;
    logic [63:0] raw;
    int          k;
    raw = {$urandom, $urandom};
    k   = $urandom_range(9);
    r.start_sector = raw[47:0];
    if (k <= 3)
      r.start_sector = {20'h0, prev.start_sector[27:24], raw[23:0]};
    else if (k <= 5)
      r.start_sector = {20'h0, raw[27:0]};
    else if (k == 6)
      r.start_sector = $urandom_range(1) ? 48'h0000_0FFF_FFFF : 48'h0000_1000_0000;
    else if (k == 9)
      r.start_sector = $urandom_range(1) ? '0 : '1;
    k = $urandom_range(7);
    r.sector_count = (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF : 16'($urandom);
    r.is_read  = 1'($urandom);
    r.use_dma  = 1'($urandom);
    r.slave_target = ($urandom_range(9) < 7) ? prev.slave_target : ~prev.slave_target;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input wr_t got, input wr_t want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch (%s) at cycle %0d: got %h, want %h", what, cycles, got, want);
  endtask

  task automatic set_idling(input idle_mode_t mode);
    snd_pct = (mode == IDLE_SENDER || mode == IDLE_BOTH) ?
              ((mode == IDLE_BOTH) ? 14 : 61) : 0;
    rcv_pct = (mode == IDLE_RECEIVER || mode == IDLE_BOTH) ?
              ((mode == IDLE_BOTH) ? 14 : 61) : 0;
  endtask

  // Present one request after a random gap and hold it until the transfer
  task automatic send_req(input req_t r, input logic fx);
    @(negedge clk);
    while ($urandom_range(99) < snd_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req        <= r;
    req_valid  <= 1'b1;
    fixed_next = fx;
    do @(posedge clk); while (!(req_valid && !req_stall));
  endtask

  // Only with nothing in flight: drain, settle, then write both registers
  task automatic apply_cfg(input logic m, input logic s);
    @(negedge clk);
    req_valid <= 1'b0;
    while (due_writes.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MASTER_LBA48;
    cfg_data  <= m;
    @(negedge clk);
    cfg_index <= CFG_SLAVE_LBA48;
    cfg_data  <= s;
    @(negedge clk);
    cfg_we <= 1'b0;
    lba48_m = m;
    lba48_s = s;
  endtask

  always @(negedge clk) begin
    wr_stall <= ($urandom_range(99) < rcv_pct);
  end

  // Checker and predictor share one process so a write and a request
  // transfer on the same edge are handled in a fixed order
  always @(posedge clk) begin
    if (!rst) begin
      if (wr_valid && !wr_stall) begin
        got_w = wr;
        if (due_writes.size() == 0) begin
          flag_mismatch("unexpected write", got_w, '0);
        end else begin
          want_w = due_writes.pop_front();
          if (got_w.target_block !== want_w.target_block)
            flag_mismatch("target_block", got_w, want_w);
          if (got_w.reg_offset !== want_w.reg_offset)
            flag_mismatch("reg_offset", got_w, want_w);
          if (got_w.write_value !== want_w.write_value)
            flag_mismatch("write_value", got_w, want_w);
          if (got_w.rejected !== want_w.rejected)
            flag_mismatch("rejected", got_w, want_w);
          if (got_w.last_write !== want_w.last_write)
            flag_mismatch("last_write", got_w, want_w);
        end
      end
      if (req_valid && !req_stall) begin
        if (fixed_next) due_writes.push_back(reject_write());
        else            plan_taskfile_writes(req);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    req_t prev;

    // 28-bit on both drives
    dir_tab.push_back(mk_row(0, 0, 48'h0, 16'h0000, 1, 0, 0, 0));
    dir_tab.push_back(mk_row(0, 0, 48'h0, 16'h0000, 1, 0, 0, 0)); // same select
    dir_tab.push_back(mk_row(0, 0, 48'h0000_0FFF_FFFF, 16'hFFFF, 0, 1, 1, 0));
    dir_tab.push_back(mk_row(0, 0, 48'h0000_1000_0000, 16'h0001, 1, 1, 0, 1));
    dir_tab.push_back(mk_row(0, 0, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 0, 0, 1, 1));
    dir_tab.push_back(mk_row(0, 0, 48'h0000_0ABC_DEF1, 16'h00A5, 1, 1, 0, 0));
    dir_tab.push_back(mk_row(0, 0, 48'h0000_0500_0000, 16'h1234, 0, 0, 1, 0));
    // 48-bit master only
    dir_tab.push_back(mk_row(1, 0, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1, 1, 0, 0));
    dir_tab.push_back(mk_row(1, 0, 48'h1234_5678_9ABC, 16'h5AA5, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(1, 0, 48'h0000_1000_0000, 16'h0000, 1, 0, 0, 0));
    dir_tab.push_back(mk_row(1, 0, 48'h0, 16'h0100, 0, 1, 0, 0));
    dir_tab.push_back(mk_row(1, 0, 48'h0000_1000_0000, 16'h0008, 0, 1, 1, 1));
    dir_tab.push_back(mk_row(1, 0, 48'h0000_0FFF_FFFF, 16'h00FF, 1, 0, 1, 0));
    // 48-bit slave only
    dir_tab.push_back(mk_row(0, 1, 48'hFFFF_FFFF_FFFF, 16'h0000, 1, 0, 1, 0));
    dir_tab.push_back(mk_row(0, 1, 48'hA5A5_A5A5_A5A5, 16'h8001, 0, 1, 1, 0));
    dir_tab.push_back(mk_row(0, 1, 48'h0001_0000_0000, 16'h0010, 1, 0, 0, 1));
    dir_tab.push_back(mk_row(0, 1, 48'h0000_0000_0001, 16'h7FFE, 0, 1, 0, 0));
    // 48-bit on both
    dir_tab.push_back(mk_row(1, 1, 48'h8000_0000_0000, 16'h4000, 1, 1, 0, 0));
    dir_tab.push_back(mk_row(1, 1, 48'h7FFF_FFFF_FFFF, 16'h00FF, 0, 0, 1, 0));
    dir_tab.push_back(mk_row(1, 1, 48'h5A5A_5A5A_5A5A, 16'hFF00, 1, 1, 1, 0));
    dir_tab.push_back(mk_row(1, 1, 48'h0, 16'h0000, 0, 0, 0, 0));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_idling(IDLE_NONE);
    foreach (dir_tab[i]) begin
      if (i == 0 || dir_tab[i].m48 != lba48_m || dir_tab[i].s48 != lba48_s)
        apply_cfg(dir_tab[i].m48, dir_tab[i].s48);
      send_req(dir_tab[i].rq, dir_tab[i].fixed_exp);
    end

    // Random traffic: each chunk gets its own lba48 setting and idling mix
    prev = dir_tab[dir_tab.size()-1].rq;
    for (int c = 0; c < RANDOM_ITEMS / CHUNK; c++) begin
      apply_cfg(c[0] ^ c[1], c[1]);
      set_idling(idle_mode_t'((c + c / 4) % 4));
      for (int i = 0; i < CHUNK; i++) begin
        prev = roll_request(prev);
        send_req(prev, 1'b0);
      end
    end

    @(negedge clk);
    req_valid <= 1'b0;
    while (due_writes.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0 && due_writes.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
